>>> rtl/core/pps_pkg.sv
// Shared types and constants for the PWM prescaler/period search unit.
// Used by the controller, the datapath and the top level; no dependencies.
package pps_pkg;

  localparam int VALUE_WIDTH_DEF     = 32;
  localparam int PRESCALER_WIDTH_DEF = 17;
  localparam int PSC_LIMIT_RESET     = 65536;
  localparam int PER_LIMIT_RESET     = 65536;
  localparam int CFG_INDEX_WIDTH     = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLOCK_HZ        = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESCALER_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PERIOD_LIMIT    = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DIV_PROD,
    OP_SET_PROD,
    OP_FAST,
    OP_DIV_PM,
    OP_SET_PSC,
    OP_DIV_PER,
    OP_SET_PER,
    OP_DIV_Q1,
    OP_SET_Q1,
    OP_DIV_GOT,
    OP_EVAL,
    OP_NEXT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load_in;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic invalid;
    logic fits;
    logic exact;
    logic last;
  } stat_t;

endpackage

>>> rtl/core/pps_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Stand-alone; used by pps_datapath.
module pps_divider #(
  parameter int VW = 32,
  parameter int W  = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [VW-1:0] dividend,
  input  logic [W-1:0]  divisor,
  output logic          done,
  output logic [VW-1:0] quotient
);

  localparam int CW = $clog2(VW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;

  assign rem_sh = {rem, quotient[VW-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        if (!diff[W]) begin
          rem      <= diff[W-1:0];
          quotient <= {quotient[VW-2:0], 1'b1};
        end else begin
          rem      <= rem_sh[W-1:0];
          quotient <= {quotient[VW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(VW-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/core/pps_datapath.sv
// Datapath: config registers, working registers, best-candidate tracking,
// result registers. Uses pps_pkg and pps_divider.
module pps_datapath #(
  parameter int VALUE_WIDTH     = pps_pkg::VALUE_WIDTH_DEF,
  parameter int PRESCALER_WIDTH = pps_pkg::PRESCALER_WIDTH_DEF,
  parameter int W = (VALUE_WIDTH > PRESCALER_WIDTH) ? VALUE_WIDTH : PRESCALER_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [W-1:0]                        cfg_data,
  input  logic [VALUE_WIDTH-1:0]              target_hz,
  input  pps_pkg::cmd_t                       cmd,
  output pps_pkg::stat_t                      stat,
  output logic                                status,
  output logic [PRESCALER_WIDTH-1:0]          prescaler,
  output logic [VALUE_WIDTH-1:0]              period,
  output logic [VALUE_WIDTH-1:0]              actual_hz
);

  localparam int VW = VALUE_WIDTH;
  localparam int PW = PRESCALER_WIDTH;

  logic [VW-1:0] clock_hz;
  logic [PW-1:0] prescaler_limit;
  logic [VW-1:0] period_limit;

  logic [VW-1:0] tgt;
  logic [VW-1:0] product;
  logic [PW-1:0] psc;
  logic [VW-1:0] per;
  logic [VW-1:0] q1;
  logic          have;
  logic [VW-1:0] err_min;
  logic [PW-1:0] best_psc;
  logic [VW-1:0] best_per;
  logic [VW-1:0] best_got;

  logic [PW-1:0] psc_max;
  logic [VW-1:0] per_max;
  logic          div_start;
  logic [VW-1:0] div_a;
  logic [W-1:0]  div_d;
  logic          div_done;
  logic [VW-1:0] q;
  logic [VW-1:0] err;
  logic [W-1:0]  q_w;

  assign psc_max = (prescaler_limit == '0) ? PW'(1) : prescaler_limit;
  assign per_max = (period_limit == '0) ? VW'(1) : period_limit;
  assign err     = (q >= tgt) ? (q - tgt) : (tgt - q);
  assign q_w     = W'(q);

  always_comb begin
    div_start = 1'b1;
    div_a     = clock_hz;
    div_d     = W'(tgt);
    case (cmd.op)
      pps_pkg::OP_DIV_PROD: begin
        div_a = clock_hz;
        div_d = W'(tgt);
      end
      pps_pkg::OP_DIV_PM: begin
        div_a = product;
        div_d = W'(per_max);
      end
      pps_pkg::OP_DIV_PER: begin
        div_a = product;
        div_d = W'(psc);
      end
      pps_pkg::OP_DIV_Q1: begin
        div_a = clock_hz;
        div_d = W'(psc);
      end
      pps_pkg::OP_DIV_GOT: begin
        div_a = q1;
        div_d = W'(per);
      end
      default: div_start = 1'b0;
    endcase
  end

  pps_divider #(.VW(VW), .W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (q)
  );

  assign stat.div_done = div_done;
  assign stat.invalid  = (clock_hz == '0) || (tgt == '0);
  assign stat.fits     = (product <= per_max);
  assign stat.exact    = (q == tgt);
  assign stat.last     = (psc == psc_max);

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz        <= '0;
      prescaler_limit <= PW'(pps_pkg::PSC_LIMIT_RESET);
      period_limit    <= VW'(pps_pkg::PER_LIMIT_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        pps_pkg::CFG_CLOCK_HZ:        clock_hz        <= cfg_data[VW-1:0];
        pps_pkg::CFG_PRESCALER_LIMIT: prescaler_limit <= cfg_data[PW-1:0];
        pps_pkg::CFG_PERIOD_LIMIT:    period_limit    <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tgt  <= target_hz;
      have <= 1'b0;
    end else begin
      case (cmd.op)
        pps_pkg::OP_SET_PROD: product <= q;
        pps_pkg::OP_FAST: begin
          psc <= PW'(1);
          per <= (product == '0) ? VW'(1) : product;
          q1  <= clock_hz;
        end
        pps_pkg::OP_SET_PSC: begin
          if (q == '0) psc <= PW'(1);
          else if (q_w > W'(psc_max)) psc <= psc_max;
          else psc <= q_w[PW-1:0];
        end
        pps_pkg::OP_SET_PER: begin
          if (q == '0) per <= VW'(1);
          else if (q > per_max) per <= per_max;
          else per <= q;
        end
        pps_pkg::OP_SET_Q1: q1 <= q;
        pps_pkg::OP_EVAL: begin
          if (!have || err < err_min) begin
            have     <= 1'b1;
            err_min  <= err;
            best_psc <= psc;
            best_per <= per;
            best_got <= q;
          end
        end
        pps_pkg::OP_NEXT: psc <= psc + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (stat.invalid) begin
        status    <= 1'b1;
        prescaler <= PW'(1);
        period    <= VW'(1);
        actual_hz <= '0;
      end else begin
        status    <= 1'b0;
        prescaler <= best_psc;
        period    <= best_per;
        actual_hz <= best_got;
      end
    end
  end

endmodule

>>> rtl/core/pps_controller.sv
// Sequencer for the search: issues datapath operations, owns the handshakes.
// Uses pps_pkg.
module pps_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  pps_pkg::stat_t stat,
  output pps_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_WPROD, S_BR, S_BR2, S_FAST, S_WPM, S_DPER,
    S_WPER, S_DQ1, S_WQ1, S_DGOT, S_WGOT, S_DEC, S_FIN
  } state_t;

  state_t         state;
  pps_pkg::op_t   op;
  logic           load_out;

  assign in_stall     = (state != S_IDLE);
  assign load_out     = (state == S_FIN) && (!out_valid || !out_stall);
  assign cmd.op       = op;
  assign cmd.load_in  = (state == S_IDLE) && in_valid;
  assign cmd.load_out = load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= pps_pkg::OP_NONE;
      out_valid <= 1'b0;
    end else begin
      op <= pps_pkg::OP_NONE;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid) begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (stat.invalid) state <= S_FIN;
          else begin
            op    <= pps_pkg::OP_DIV_PROD;
            state <= S_WPROD;
          end
        end
        S_WPROD: if (stat.div_done) begin
          op    <= pps_pkg::OP_SET_PROD;
          state <= S_BR;
        end
        S_BR: state <= S_BR2;
        S_BR2: begin
          if (stat.fits) begin
            op    <= pps_pkg::OP_FAST;
            state <= S_FAST;
          end else begin
            op    <= pps_pkg::OP_DIV_PM;
            state <= S_WPM;
          end
        end
        S_FAST: begin
          op    <= pps_pkg::OP_DIV_GOT;
          state <= S_WGOT;
        end
        S_WPM: if (stat.div_done) begin
          op    <= pps_pkg::OP_SET_PSC;
          state <= S_DPER;
        end
        S_DPER: begin
          op    <= pps_pkg::OP_DIV_PER;
          state <= S_WPER;
        end
        S_WPER: if (stat.div_done) begin
          op    <= pps_pkg::OP_SET_PER;
          state <= S_DQ1;
        end
        S_DQ1: begin
          op    <= pps_pkg::OP_DIV_Q1;
          state <= S_WQ1;
        end
        S_WQ1: if (stat.div_done) begin
          op    <= pps_pkg::OP_SET_Q1;
          state <= S_DGOT;
        end
        S_DGOT: begin
          op    <= pps_pkg::OP_DIV_GOT;
          state <= S_WGOT;
        end
        S_WGOT: if (stat.div_done) begin
          op    <= pps_pkg::OP_EVAL;
          state <= S_DEC;
        end
        S_DEC: begin
          if (stat.fits || stat.exact || stat.last) state <= S_FIN;
          else begin
            op    <= pps_pkg::OP_NEXT;
            state <= S_DPER;
          end
        end
        S_FIN: if (load_out) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/pwm_prescaler_period_search_unit.sv
// PWM prescaler/period search, top level: controller plus datapath.
// An invalid request goes straight to the result; a direct fit evaluates
// prescaler 1 only; otherwise prescalers are tried in turn, counting up.
// One item at a time; the shared bit-serial divider sets the rate.
// A new item is taken while a result waits. Synchronous reset clears
// control state and sets the configuration registers to their defaults.
module pwm_prescaler_period_search_unit #(
  parameter int VALUE_WIDTH     = pps_pkg::VALUE_WIDTH_DEF,
  parameter int PRESCALER_WIDTH = pps_pkg::PRESCALER_WIDTH_DEF,
  parameter int W = (VALUE_WIDTH > PRESCALER_WIDTH) ? VALUE_WIDTH : PRESCALER_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [W-1:0]                        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [VALUE_WIDTH-1:0]              target_hz,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                status,
  output logic [PRESCALER_WIDTH-1:0]          prescaler,
  output logic [VALUE_WIDTH-1:0]              period,
  output logic [VALUE_WIDTH-1:0]              actual_hz
);

  pps_pkg::cmd_t  cmd;
  pps_pkg::stat_t stat;

  pps_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pps_datapath #(
    .VALUE_WIDTH     (VALUE_WIDTH),
    .PRESCALER_WIDTH (PRESCALER_WIDTH),
    .W               (W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .target_hz (target_hz),
    .cmd       (cmd),
    .stat      (stat),
    .status    (status),
    .prescaler (prescaler),
    .period    (period),
    .actual_hz (actual_hz)
  );

endmodule

>>> rtl/core/pps_checker.sv
// Port-level checks for the search unit, bound to the top level.
// Depends only on the top level's ports.
module pps_checker #(
  parameter int VALUE_WIDTH     = 32,
  parameter int PRESCALER_WIDTH = 17
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       status,
  input logic [PRESCALER_WIDTH-1:0] prescaler,
  input logic [VALUE_WIDTH-1:0]     period,
  input logic [VALUE_WIDTH-1:0]     actual_hz
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(prescaler) && $stable(period) && $stable(actual_hz))
    else $error("stalled result changed");

  a_invalid_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> prescaler == 1 && period == 1 && actual_hz == 0)
    else $error("invalid result fields wrong");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> prescaler != 0 && period != 0)
    else $error("zero prescaler or period");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("not busy after item accepted");

endmodule

bind pwm_prescaler_period_search_unit pps_checker #(
  .VALUE_WIDTH     (VALUE_WIDTH),
  .PRESCALER_WIDTH (PRESCALER_WIDTH)
) u_pps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .prescaler (prescaler),
  .period    (period),
  .actual_hz (actual_hz)
);
